FILE: rtl/decimal_string_to_fixed_point_defines.svh
// Assertion macros shared by the decimal string to fixed point RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef DECIMAL_STRING_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_STRING_TO_FIXED_POINT_DEFINES_SVH

// same-cycle implication
`define DSTFP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dstfp_pkg.sv
// Types, constants and tables for the decimal string to fixed point block.
// No dependencies.
package dstfp_pkg;

  localparam int WHOLE_W = 34;
  localparam int FRAC_W  = 30;
  localparam int COUNT_W = 4;
  localparam int VALUE_W = 64;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCOUNT_W    = 2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  localparam logic [1:0] UNIT_NANO  = 2'd0;
  localparam logic [1:0] UNIT_MICRO = 2'd1;
  localparam logic [1:0] UNIT_MILLI = 2'd2;

  localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 34'd9223372036;
  localparam logic [FRAC_W-1:0]  NANO_SCALE  = 30'd1000000000;
  localparam logic [FRAC_W-1:0]  MICRO_SCALE = 30'd1000000;
  localparam logic [FRAC_W-1:0]  MILLI_SCALE = 30'd1000;

  // floor(x/d) = (x*ceil(2^n/d)) >> n for x < 2^30
  localparam logic [30:0] RECIP_MICRO = 31'd1099511628;
  localparam int          SHIFT_MICRO = 40;
  localparam logic [30:0] RECIP_MILLI = 31'd1125899907;
  localparam int          SHIFT_MILLI = 50;

  localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // one finished string, handed from the parser to the scaler
  typedef struct packed {
    logic               negative;
    logic               invalid_seen;
    logic               overflow_seen;
    logic [1:0]         unit;
    logic [WHOLE_W-1:0] whole_acc;
    logic [FRAC_W-1:0]  fraction_acc;
    logic [COUNT_W-1:0] fraction_count;
  } rec_t;

  // 10^(9 - count), count clamped at 9
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [COUNT_W-1:0] count);
    logic [FRAC_W-1:0] w;
    case (count)
      4'd0:    w = 30'd1000000000;
      4'd1:    w = 30'd100000000;
      4'd2:    w = 30'd10000000;
      4'd3:    w = 30'd1000000;
      4'd4:    w = 30'd100000;
      4'd5:    w = 30'd10000;
      4'd6:    w = 30'd1000;
      4'd7:    w = 30'd100;
      4'd8:    w = 30'd10;
      default: w = 30'd1;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/dstfp_parse.sv
// Front end: takes one character per cycle unless stalled; keeps parse state.
// On NUL it pushes the finished string record into the queue. Uses dstfp_pkg.
module dstfp_parse #(
  parameter int FRACTION_DIGITS = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       character,
  input  logic [1:0]       unit,
  input  logic             q_full,
  output logic             push,
  output dstfp_pkg::rec_t  push_rec
);
  import dstfp_pkg::*;

  logic               first_char, first_char_next;
  logic               negative, negative_next;
  logic               in_fraction, in_fraction_next;
  logic [WHOLE_W-1:0] whole_acc, whole_acc_next;
  logic [FRAC_W-1:0]  fraction_acc, fraction_acc_next;
  logic [COUNT_W-1:0] fraction_count, fraction_count_next;
  logic               invalid_seen, invalid_seen_next;
  logic               overflow_seen, overflow_seen_next;

  logic               accept;
  logic               is_digit;
  logic [3:0]         digit;
  logic [37:0]        whole_ext;
  logic [37:0]        whole_calc;
  logic [FRAC_W-1:0]  frac_calc;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
  assign digit    = 4'(character - CHAR_ZERO);

  assign whole_ext  = {4'd0, whole_acc};
  assign whole_calc = (whole_ext << 3) + (whole_ext << 1) + {34'd0, digit};
  assign frac_calc  = (fraction_acc << 3) + (fraction_acc << 1) + {26'd0, digit};

  always_comb begin
    first_char_next     = first_char;
    negative_next       = negative;
    in_fraction_next    = in_fraction;
    whole_acc_next      = whole_acc;
    fraction_acc_next   = fraction_acc;
    fraction_count_next = fraction_count;
    invalid_seen_next   = invalid_seen;
    overflow_seen_next  = overflow_seen;
    push                = 1'b0;

    push_rec.negative       = negative;
    push_rec.invalid_seen   = invalid_seen;
    push_rec.overflow_seen  = overflow_seen;
    push_rec.unit           = unit;
    push_rec.whole_acc      = whole_acc;
    push_rec.fraction_acc   = fraction_acc;
    push_rec.fraction_count = fraction_count;

    if (accept) begin
      if (character == CHAR_NUL) begin
        push                = 1'b1;
        first_char_next     = 1'b1;
        negative_next       = 1'b0;
        in_fraction_next    = 1'b0;
        whole_acc_next      = '0;
        fraction_acc_next   = '0;
        fraction_count_next = '0;
        invalid_seen_next   = 1'b0;
        overflow_seen_next  = 1'b0;
      end else begin
        first_char_next = 1'b0;
        if (is_digit) begin
          if (in_fraction) begin
            // digits past the kept count are checked but dropped
            if (fraction_count < COUNT_W'(FRACTION_DIGITS)) begin
              fraction_acc_next   = frac_calc;
              fraction_count_next = fraction_count + 4'd1;
            end
          end else if (whole_calc > {4'd0, WHOLE_LIMIT}) begin
            overflow_seen_next = 1'b1;
            whole_acc_next     = WHOLE_LIMIT;
          end else begin
            whole_acc_next = whole_calc[WHOLE_W-1:0];
          end
        end else if (character == CHAR_MINUS && first_char) begin
          negative_next = 1'b1;
        end else if (character == CHAR_POINT && !in_fraction) begin
          in_fraction_next = 1'b1;
        end else begin
          invalid_seen_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_char     <= 1'b1;
      negative       <= 1'b0;
      in_fraction    <= 1'b0;
      whole_acc      <= '0;
      fraction_acc   <= '0;
      fraction_count <= '0;
      invalid_seen   <= 1'b0;
      overflow_seen  <= 1'b0;
    end else begin
      first_char     <= first_char_next;
      negative       <= negative_next;
      in_fraction    <= in_fraction_next;
      whole_acc      <= whole_acc_next;
      fraction_acc   <= fraction_acc_next;
      fraction_count <= fraction_count_next;
      invalid_seen   <= invalid_seen_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

endmodule

FILE: rtl/dstfp_queue.sv
// Two-entry queue of string records between the parser and the scaler.
// Uses dstfp_pkg and the shared assertion macros.
`include "decimal_string_to_fixed_point_defines.svh"

module dstfp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dstfp_pkg::rec_t  push_rec,
  output logic             full,
  input  logic             pop,
  output dstfp_pkg::rec_t  pop_rec,
  output logic             empty
);
  import dstfp_pkg::*;

  rec_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign full    = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `DSTFP_ASSERT_IMPLY(a_no_push_full, push, !full, "queue push while full")
  `DSTFP_ASSERT_IMPLY(a_no_pop_empty, pop, !empty, "queue pop while empty")
  `DSTFP_ASSERT_IMPLY(a_count_bound, 1'b1, count <= QCOUNT_W'(QUEUE_DEPTH), "queue count overrun")

endmodule

FILE: rtl/dstfp_scale.sv
// Back end: scales a string record to nano, micro or milli units and checks the bound.
// Four registered stages; uses dstfp_pkg and the shared assertion macros.
`include "decimal_string_to_fixed_point_defines.svh"

module dstfp_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  dstfp_pkg::rec_t               q_rec,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [dstfp_pkg::VALUE_W-1:0] value,
  output logic [1:0]                    status
);
  import dstfp_pkg::*;

  logic advance;

  // stage 1: fraction weighting and whole * 1e9
  logic               v1;
  logic               s1_neg, s1_inv, s1_ovf;
  logic [1:0]         s1_unit;
  logic [WHOLE_W-1:0] s1_whole;
  logic [FRAC_W-1:0]  s1_frac;
  logic [VALUE_W-1:0] s1_whole_nano;
  logic [59:0]        frac_prod;
  logic [VALUE_W-1:0] whole_nano_prod;

  // stage 2: nano magnitude, whole in unit, fraction in unit
  logic               v2;
  logic               s2_neg, s2_inv, s2_ovf;
  logic [VALUE_W-1:0] s2_mag;
  logic [VALUE_W-1:0] s2_whole_unit;
  logic [FRAC_W-1:0]  s2_frac_unit;
  logic [FRAC_W-1:0]  unit_scale;
  logic [30:0]        unit_recip;
  logic [60:0]        recip_prod;
  logic [FRAC_W-1:0]  frac_unit;
  logic [VALUE_W-1:0] whole_unit_prod;

  // stage 3: bound check and unit magnitude
  logic               v3;
  logic               s3_neg;
  status_t            s3_status;
  logic [VALUE_W-1:0] s3_mag;
  logic               too_big;
  status_t            status_calc;

  // output register
  status_t            out_status;
  logic               out_neg;

  assign advance = !(out_valid && out_stall);
  assign pop     = advance && !q_empty;

  assign frac_prod       = q_rec.fraction_acc * frac_weight(q_rec.fraction_count);
  assign whole_nano_prod = q_rec.whole_acc * NANO_SCALE;

  always_comb begin
    case (s1_unit)
      UNIT_MICRO: begin
        unit_scale = MICRO_SCALE;
        unit_recip = RECIP_MICRO;
      end
      UNIT_MILLI: begin
        unit_scale = MILLI_SCALE;
        unit_recip = RECIP_MILLI;
      end
      default: begin
        unit_scale = NANO_SCALE;
        unit_recip = '0;
      end
    endcase
  end

  assign recip_prod      = s1_frac * unit_recip;
  assign whole_unit_prod = s1_whole * unit_scale;

  always_comb begin
    case (s1_unit)
      UNIT_MICRO: frac_unit = {9'd0, recip_prod[60:SHIFT_MICRO]};
      UNIT_MILLI: frac_unit = {19'd0, recip_prod[60:SHIFT_MILLI]};
      default:    frac_unit = s1_frac;
    endcase
  end

  // the whole part scales exactly, so only the fraction is truncated
  assign too_big = s2_mag > (s2_neg ? NEG_LIMIT : POS_LIMIT);

  always_comb begin
    if (s2_inv) begin
      status_calc = STATUS_INVALID;
    end else if (s2_ovf || too_big) begin
      status_calc = STATUS_OVERFLOW;
    end else begin
      status_calc = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_neg        <= q_rec.negative;
      s1_inv        <= q_rec.invalid_seen;
      s1_ovf        <= q_rec.overflow_seen;
      s1_unit       <= q_rec.unit;
      s1_whole      <= q_rec.whole_acc;
      s1_frac       <= frac_prod[FRAC_W-1:0];
      s1_whole_nano <= whole_nano_prod;

      s2_neg        <= s1_neg;
      s2_inv        <= s1_inv;
      s2_ovf        <= s1_ovf;
      s2_mag        <= s1_whole_nano + {34'd0, s1_frac};
      s2_whole_unit <= whole_unit_prod;
      s2_frac_unit  <= frac_unit;

      s3_neg        <= s2_neg;
      s3_status     <= status_calc;
      s3_mag        <= s2_whole_unit + {34'd0, s2_frac_unit};

      out_neg       <= s3_neg;
      out_status    <= s3_status;
      if (s3_status == STATUS_OK) begin
        value <= s3_neg ? -$signed(s3_mag) : $signed(s3_mag);
      end else begin
        value <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= !q_empty;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  assign status = out_status;

  `DSTFP_ASSERT_IMPLY(a_err_zero, out_valid && out_status != STATUS_OK, value == '0, "nonzero value with error status")
  `DSTFP_ASSERT_IMPLY(a_pos_sign, out_valid && out_status == STATUS_OK && !out_neg, !value[VALUE_W-1], "positive result has sign bit set")
  `DSTFP_ASSERT_NEXT(a_drain, v3 && advance, out_valid, "stage 3 item lost on the way out")

endmodule

FILE: rtl/decimal_string_to_fixed_point.sv
// Top level of the decimal string to fixed point block: parser, queue, scaler.
// Uses dstfp_pkg, dstfp_parse, dstfp_queue and dstfp_scale.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   character[7:0], unit[1:0]
//   output   out        out_valid / out_stall value[63:0] signed, status[1:0]
//
// One character is taken per cycle unless in_stall; only NUL produces a result.
// After its NUL, a record passes through the queue, then the scaler's registers.
// The scaler runs one record per cycle; out_stall holds its stages, the queue
// then fills and in_stall rises while both queue entries are taken.
// Reset (rst, synchronous) empties the queue and the stages and clears the parse.
module decimal_string_to_fixed_point #(
  parameter int FRACTION_DIGITS = 9
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           character,
  input  logic [1:0]                           unit,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dstfp_pkg::VALUE_W-1:0] value,
  output logic [1:0]                           status
);
  import dstfp_pkg::*;

  logic push;
  rec_t push_rec;
  logic q_full;
  logic pop;
  rec_t pop_rec;
  logic q_empty;

  dstfp_parse #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .character(character),
    .unit     (unit),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  dstfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .full    (q_full),
    .pop     (pop),
    .pop_rec (pop_rec),
    .empty   (q_empty)
  );

  dstfp_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rec    (pop_rec),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .status   (status)
  );

endmodule
